FILE: hdl/height_to_hue_ramp_colour_unit_defines.svh
// Assertion macros shared by the height to hue-ramp colour unit.
`ifndef HEIGHT_TO_HUE_RAMP_COLOUR_UNIT_DEFINES_SVH
`define HEIGHT_TO_HUE_RAMP_COLOUR_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define HHR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define HHR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/hhr_pkg.sv
// Shared constants for the height to hue-ramp colour unit.
package hhr_pkg;

    localparam int HEIGHT_BITS = 16;

    // Hue ramp: four segments of 255 steps each.
    localparam int SEG_W      = 8;
    localparam int POS_W      = 10;
    localparam int Q_W        = POS_W + 1;
    localparam int DIV_W      = HEIGHT_BITS + 1;
    localparam int DVD_W      = HEIGHT_BITS + Q_W;
    localparam int CNT_W      = $clog2(Q_W);

    localparam logic [POS_W-1:0] HUE_SPAN = POS_W'(1020);
    localparam logic [POS_W-1:0] SEG      = POS_W'(255);

    // Item actions.
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_EXTEND = 2'd1;
    localparam logic [1:0] ACT_COLOUR = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

endpackage

FILE: hdl/hhr_chan_if.sv
// Valid/ready channel interfaces for height items and colour results.
interface hhr_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             action;
    logic signed [hhr_pkg::HEIGHT_BITS-1:0] height;

    modport source (output valid, output action, output height, input ready);
    modport sink   (input valid, input action, input height, output ready);
endinterface

interface hhr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: hdl/hhr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module hhr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hhr_pkg::DVD_W-1:0]  i_dividend,
    input  logic [hhr_pkg::DIV_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [hhr_pkg::Q_W-1:0]    o_quotient
);

    logic                        r_busy;
    logic                        r_done;
    logic [hhr_pkg::CNT_W-1:0]   r_cnt;
    logic [hhr_pkg::DIV_W-1:0]   r_rem;
    logic [hhr_pkg::Q_W-1:0]     r_low;
    logic [hhr_pkg::DIV_W-1:0]   r_dvs;

    logic [hhr_pkg::DIV_W+1:0]   trial;
    logic                        qbit;

    // Trial subtract of the divisor from the remainder with the next bit shifted in.
    always_comb begin
        trial = {1'b0, r_rem, r_low[hhr_pkg::Q_W-1]} - {2'b00, r_dvs};
        qbit  = ~trial[hhr_pkg::DIV_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == hhr_pkg::CNT_W'(hhr_pkg::Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Low bits of the dividend shift out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= hhr_pkg::DIV_W'(i_dividend[hhr_pkg::DVD_W-1:hhr_pkg::Q_W]);
            r_low <= i_dividend[hhr_pkg::Q_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (qbit) begin
                r_rem <= trial[hhr_pkg::DIV_W-1:0];
            end else begin
                r_rem <= {r_rem[hhr_pkg::DIV_W-2:0], r_low[hhr_pkg::Q_W-1]};
            end
            r_low <= {r_low[hhr_pkg::Q_W-2:0], qbit};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_low;

endmodule

FILE: hdl/height_to_hue_ramp_colour_unit.sv
// Height to hue-ramp colour unit: range tracking and RGB false-colour mapping.
//
// Use: present every height twice on i_item. First pass: action START opens a
// new set with the height, action EXTEND widens the running min/max. Both give
// no result. Second pass: action COLOUR places the height on a hue position
// (max - h) * 1020 / (max - min), rounded, and returns one RGB result on o_item,
// red at the max through yellow, green, cyan to blue at min.
// Action code 3 is dropped without a result.
// A colour item goes from the prep step straight to the map step when the height
// sits at or outside the range or the range is zero, and through the 11-step
// restoring divider otherwise; the unit is not ready from the transfer of a
// colour item until its result leaves the map step.
// A finished result waits in the output register; while it waits, range items
// and the next colour item are still taken, and a new result holds in the map
// step until the receiver takes the old one.
// Reset clears min and max to zero and empties the output register.

`include "height_to_hue_ramp_colour_unit_defines.svh"

module height_to_hue_ramp_colour_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hhr_in_if.sink     i_item,
    hhr_out_if.source  o_item
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_MAP  = 2'd3;

    localparam int HB = hhr_pkg::HEIGHT_BITS;

    logic [1:0]                       r_state;
    logic signed [HB-1:0]             r_lo;
    logic signed [HB-1:0]             r_hi;
    logic signed [HB-1:0]             r_h;
    logic [hhr_pkg::POS_W-1:0]        r_p;
    logic                             r_out_valid;
    logic [7:0]                       r_red;
    logic [7:0]                       r_green;
    logic [7:0]                       r_blue;

    logic                             in_xfer;
    logic                             out_xfer;
    logic                             load_out;
    logic signed [HB:0]               diff_rng;
    logic signed [HB:0]               diff_num;
    logic [HB-1:0]                    range_u;
    logic [HB-1:0]                    num_u;
    logic [hhr_pkg::DVD_W-1:0]        dividend;
    logic [hhr_pkg::DIV_W-1:0]        divisor;
    logic                             div_start;
    logic                             div_busy;
    logic                             div_done;
    logic [hhr_pkg::Q_W-1:0]          div_q;
    logic [1:0]                       seg_idx;
    logic [hhr_pkg::POS_W-1:0]        seg_frac;
    logic [7:0]                       n_red;
    logic [7:0]                       n_green;
    logic [7:0]                       n_blue;

    assign i_item.ready = (r_state == S_IDLE);
    assign in_xfer      = i_item.valid && i_item.ready;
    assign out_xfer     = o_item.valid && o_item.ready;
    assign load_out     = (r_state == S_MAP) && (!r_out_valid || o_item.ready);

    // Range and distance from the top; both are non-negative in the divide path.
    always_comb begin
        diff_rng = {r_hi[HB-1], r_hi} - {r_lo[HB-1], r_lo};
        diff_num = {r_hi[HB-1], r_hi} - {r_h[HB-1], r_h};
        range_u  = diff_rng[HB-1:0];
        num_u    = diff_num[HB-1:0];
        // num * 2040 + range, over a divisor of 2 * range: rounds halves up.
        dividend = (hhr_pkg::DVD_W'(num_u) << 11) - (hhr_pkg::DVD_W'(num_u) << 3)
                 + hhr_pkg::DVD_W'(range_u);
        divisor  = {range_u, 1'b0};
    end

    assign div_start = (r_state == S_PREP) && (diff_rng != '0)
                    && (r_h < r_hi) && (r_h > r_lo);

    hhr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Split the hue position into segment and offset within it.
    always_comb begin
        priority if (r_p >= hhr_pkg::POS_W'(3 * hhr_pkg::SEG)) begin
            seg_idx  = 2'd3;
            seg_frac = r_p - hhr_pkg::POS_W'(3 * hhr_pkg::SEG);
        end else if (r_p >= hhr_pkg::POS_W'(2 * hhr_pkg::SEG)) begin
            seg_idx  = 2'd2;
            seg_frac = r_p - hhr_pkg::POS_W'(2 * hhr_pkg::SEG);
        end else if (r_p >= hhr_pkg::SEG) begin
            seg_idx  = 2'd1;
            seg_frac = r_p - hhr_pkg::SEG;
        end else begin
            seg_idx  = 2'd0;
            seg_frac = r_p;
        end
    end

    always_comb begin
        n_red   = 8'd0;
        n_green = 8'd0;
        n_blue  = 8'd255;
        if (r_p != hhr_pkg::HUE_SPAN) begin
            unique case (seg_idx)
                2'd0: begin
                    n_red   = 8'd255;
                    n_green = seg_frac[7:0];
                    n_blue  = 8'd0;
                end
                2'd1: begin
                    n_red   = 8'd255 - seg_frac[7:0];
                    n_green = 8'd255;
                    n_blue  = 8'd0;
                end
                2'd2: begin
                    n_red   = 8'd0;
                    n_green = 8'd255;
                    n_blue  = seg_frac[7:0];
                end
                2'd3: begin
                    n_red   = 8'd0;
                    n_green = 8'd255 - seg_frac[7:0];
                    n_blue  = 8'd255;
                end
                default: begin
                    n_red   = 8'd0;
                    n_green = 8'd0;
                    n_blue  = 8'd255;
                end
            endcase
        end
    end

    // Sequencer and range registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lo    <= '0;
            r_hi    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        unique case (i_item.action)
                            hhr_pkg::ACT_START: begin
                                r_lo <= i_item.height;
                                r_hi <= i_item.height;
                            end
                            hhr_pkg::ACT_EXTEND: begin
                                if (i_item.height < r_lo) r_lo <= i_item.height;
                                if (i_item.height > r_hi) r_hi <= i_item.height;
                            end
                            hhr_pkg::ACT_COLOUR: r_state <= S_PREP;
                            hhr_pkg::ACT_UNUSED: r_state <= S_IDLE;
                            default:             r_state <= S_IDLE;
                        endcase
                    end
                end
                S_PREP: r_state <= div_start ? S_DIV : S_MAP;
                S_DIV: begin
                    if (div_done) r_state <= S_MAP;
                end
                S_MAP: begin
                    if (load_out) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Hue position: saturate at or outside the range or on a zero range, else take the divider result.
    always_ff @(posedge i_clk) begin
        if (in_xfer) r_h <= i_item.height;
        if (r_state == S_PREP) begin
            priority if (diff_rng == '0) begin
                r_p <= hhr_pkg::HUE_SPAN;
            end else if (r_h >= r_hi) begin
                r_p <= '0;
            end else if (r_h <= r_lo) begin
                r_p <= hhr_pkg::HUE_SPAN;
            end else begin
                r_p <= r_p;
            end
        end else if ((r_state == S_DIV) && div_done) begin
            r_p <= div_q[hhr_pkg::POS_W-1:0];
        end
    end

    // Output register: hold until the receiver takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_item.valid = r_out_valid;
    assign o_item.red   = r_red;
    assign o_item.green = r_green;
    assign o_item.blue  = r_blue;

    `HHR_ASSERT_NOW(a_range_order, 1'b1, r_hi >= r_lo, "range max below range min")
    `HHR_ASSERT_NOW(a_ready_div_idle, i_item.ready, !div_busy, "ready while divider busy")
    `HHR_ASSERT_NEXT(a_div_to_map, (r_state == S_DIV) && div_done, r_state == S_MAP,
        "divider result not taken to map step")
    `HHR_ASSERT_NEXT(a_colour_busy, in_xfer && (i_item.action == hhr_pkg::ACT_COLOUR),
        r_state == S_PREP, "colour transfer did not start work")

endmodule

FILE: verif/height_to_hue_ramp_colour_unit_checker.sv
// Checker for the height to hue-ramp colour unit: range tracking, colour prediction, compare.
`timescale 1ns / 100ps

module height_to_hue_ramp_colour_unit_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    hhr_in_if    i_in_ch,
    hhr_out_if   i_out_ch,
    output int   o_fail_count,
    output int   o_open_count
);

    localparam int HB         = hhr_pkg::HEIGHT_BITS;
    localparam int RAMP_SPAN  = 1020;
    localparam int RAMP_STEP  = 255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic signed [HB-1:0] range_low;
    logic signed [HB-1:0] range_high;
    t_rgb                 colour_fifo[$];
    int                   fail_total;

    assign o_fail_count = fail_total;

    // Place a height on the 0..1020 hue position and map it to RGB.
    function automatic t_rgb ramp_colour(input logic signed [HB-1:0] h,
                                         input logic signed [HB-1:0] lo,
                                         input logic signed [HB-1:0] hi);
        longint span;
        longint from_top;
        int     pos;
        int     seg_idx;
        int     frac;
        t_rgb   c;
        span = longint'(hi) - longint'(lo);
        if (span <= 0) begin
            pos = RAMP_SPAN;
        end else if (h >= hi) begin
            pos = 0;
        end else if (h <= lo) begin
            pos = RAMP_SPAN;
        end else begin
            // Round halves up, exactly in integers.
            from_top = longint'(hi) - longint'(h);
            pos      = int'((from_top * 2 * RAMP_SPAN + span) / (2 * span));
        end
        seg_idx = pos / RAMP_STEP;
        frac    = pos % RAMP_STEP;
        case (seg_idx)
            0: begin
                c.red = 8'd255;           c.green = 8'(frac);         c.blue = 8'd0;
            end
            1: begin
                c.red = 8'(255 - frac);   c.green = 8'd255;           c.blue = 8'd0;
            end
            2: begin
                c.red = 8'd0;             c.green = 8'd255;           c.blue = 8'(frac);
            end
            3: begin
                c.red = 8'd0;             c.green = 8'(255 - frac);   c.blue = 8'd255;
            end
            default: begin
                c.red = 8'd0;             c.green = 8'd0;             c.blue = 8'd255;
            end
        endcase
        return c;
    endfunction

    initial fail_total = 0;

    always @(posedge i_clk) begin
        t_rgb want;
        if (!i_rst_n) begin
            range_low  = '0;
            range_high = '0;
            colour_fifo.delete();
            o_open_count <= 0;
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                case (i_in_ch.action)
                    hhr_pkg::ACT_START: begin
                        range_low  = i_in_ch.height;
                        range_high = i_in_ch.height;
                    end
                    hhr_pkg::ACT_EXTEND: begin
                        if (i_in_ch.height < range_low)  range_low  = i_in_ch.height;
                        if (i_in_ch.height > range_high) range_high = i_in_ch.height;
                    end
                    hhr_pkg::ACT_COLOUR: begin
                        colour_fifo.push_back(ramp_colour(i_in_ch.height, range_low,
                                                          range_high));
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (colour_fifo.size() == 0) begin
                    $error("unexpected colour result (%0d, %0d, %0d)",
                           i_out_ch.red, i_out_ch.green, i_out_ch.blue);
                    fail_total++;
                end else begin
                    want = colour_fifo.pop_front();
                    if (i_out_ch.red !== want.red) begin
                        $error("red: expected %0d, actual %0d", want.red, i_out_ch.red);
                        fail_total++;
                    end
                    if (i_out_ch.green !== want.green) begin
                        $error("green: expected %0d, actual %0d", want.green, i_out_ch.green);
                        fail_total++;
                    end
                    if (i_out_ch.blue !== want.blue) begin
                        $error("blue: expected %0d, actual %0d", want.blue, i_out_ch.blue);
                        fail_total++;
                    end
                end
            end
            o_open_count <= colour_fifo.size();
        end
    end

endmodule

FILE: verif/height_to_hue_ramp_colour_unit_tb.sv
// Top of the height to hue-ramp colour unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module height_to_hue_ramp_colour_unit_tb;

    localparam int HB          = hhr_pkg::HEIGHT_BITS;
    localparam int ITEM_TARGET = 1450;
    // Settle time after the last result, long enough for a colour item to finish.
    localparam int DRAIN_CYCLES = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hhr_in_if  in_ch ();
    hhr_out_if out_ch ();

    int   fail_count;
    int   open_count;
    int   heights_sent;
    // Hold the source in back-to-back mode while set; drawn anew per data set.
    logic src_burst;

    height_to_hue_ramp_colour_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_ch),
        .o_item  (out_ch)
    );

    height_to_hue_ramp_colour_unit_checker colour_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    always #10 i_clk = ~i_clk;

    // Pick an idle gap before the next transfer: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (src_burst)  return 0;
        if (r < 55)     return 0;
        if (r < 85)     return $urandom_range(1, 3);
        if (r < 97)     return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Pick a height for a data set: full range, tight cluster, wide cluster or extreme.
    function automatic logic signed [HB-1:0] pick_height(input int style,
                                                         input logic signed [HB-1:0] base);
        logic signed [HB-1:0] extremes[5];
        extremes = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1};
        case (style)
            0:       return HB'($urandom);
            1:       return base + HB'($urandom_range(0, 15)) - HB'(8);
            2:       return extremes[$urandom_range(0, 4)];
            default: return base + HB'($urandom_range(0, 1023)) - HB'(512);
        endcase
    endfunction

    // Present one item after a random gap and hold it until the transfer.
    // Leave valid high on return; the next call either replaces the item or
    // drops valid, so valid only ever sees one assignment per edge.
    task automatic send_height(input logic [1:0] act, input logic signed [HB-1:0] h);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.height <= h;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (act != hhr_pkg::ACT_UNUSED) heights_sent++;
    endtask

    // Receiver side: stretches of steady acceptance mixed with short and long stalls.
    initial begin
        int   run;
        logic lvl;
        int   r;
        run = 0;
        lvl = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (run == 0) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    lvl = 1'b1;
                    run = $urandom_range(50, 300);
                end else if (r < 60) begin
                    lvl = 1'b1;
                    run = $urandom_range(1, 4);
                end else if (r < 95) begin
                    lvl = 1'b0;
                    run = $urandom_range(1, 3);
                end else begin
                    lvl = 1'b0;
                    run = $urandom_range(20, 60);
                end
            end
            out_ch.ready <= lvl;
            run--;
        end
    end

    // Stimulus and verdict.
    initial begin
        logic signed [HB-1:0] set_heights[$];
        logic signed [HB-1:0] base;
        int                   set_size;
        int                   style;
        int                   flaw;
        int                   k;

        heights_sent = 0;
        src_burst    = 1'b0;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.action <= hhr_pkg::ACT_START;
        in_ch.height <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        // Colour straight after reset: zero range gives blue.
        send_height(hhr_pkg::ACT_COLOUR, 16'sd0);
        // Extend without a start: the range grows from 0..0 to 0..100.
        send_height(hhr_pkg::ACT_EXTEND, 16'sd100);
        send_height(hhr_pkg::ACT_COLOUR, 16'sd100);    // at the max: red
        send_height(hhr_pkg::ACT_COLOUR, 16'sd0);      // at the min: blue
        send_height(hhr_pkg::ACT_COLOUR, 16'sd50);     // middle: green
        send_height(hhr_pkg::ACT_COLOUR, 16'sd101);    // above the range: red
        send_height(hhr_pkg::ACT_COLOUR, -16'sd5);     // below the range: blue
        // Unused action code with all height bits set: dropped, no result.
        send_height(hhr_pkg::ACT_UNUSED, -16'sd1);
        // Full-scale range.
        send_height(hhr_pkg::ACT_START, 16'sh7FFF);
        send_height(hhr_pkg::ACT_EXTEND, 16'sh8000);
        send_height(hhr_pkg::ACT_COLOUR, 16'sh7FFF);
        send_height(hhr_pkg::ACT_COLOUR, 16'sh8000);
        send_height(hhr_pkg::ACT_COLOUR, 16'sd0);
        send_height(hhr_pkg::ACT_COLOUR, -16'sd1);
        send_height(hhr_pkg::ACT_COLOUR, 16'sd16383);
        // Range of 8: positions 127.5 and 892.5 check rounding of halves.
        send_height(hhr_pkg::ACT_START, 16'sd0);
        send_height(hhr_pkg::ACT_EXTEND, 16'sd8);
        send_height(hhr_pkg::ACT_COLOUR, 16'sd7);
        send_height(hhr_pkg::ACT_COLOUR, 16'sd1);
        // A new start replaces the range; zero range is blue even above it.
        send_height(hhr_pkg::ACT_START, -16'sd100);
        send_height(hhr_pkg::ACT_COLOUR, -16'sd100);
        send_height(hhr_pkg::ACT_COLOUR, 16'sd5);

        // Random part: data sets presented twice, with some noise and broken sets.
        while (heights_sent < ITEM_TARGET) begin
            set_size  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                    : $urandom_range(1, 8);
            style     = $urandom_range(0, 3);
            base      = HB'($urandom);
            flaw      = $urandom_range(0, 19);
            src_burst = ($urandom_range(0, 7) == 0);
            set_heights.delete();
            for (k = 0; k < set_size; k++) set_heights.push_back(pick_height(style, base));

            // First pass: open and widen the range, unless the set is broken.
            if (flaw != 1) begin
                for (k = 0; k < set_size; k++) begin
                    if (k == 0 && flaw != 0)
                        send_height(hhr_pkg::ACT_START, set_heights[k]);
                    else
                        send_height(hhr_pkg::ACT_EXTEND, set_heights[k]);
                    if ($urandom_range(0, 29) == 0)
                        send_height(hhr_pkg::ACT_UNUSED, HB'($urandom));
                end
            end
            // Second pass: colour every height, now and then an extra one from the full range.
            for (k = 0; k < set_size; k++) begin
                send_height(hhr_pkg::ACT_COLOUR, set_heights[k]);
                if ($urandom_range(0, 7) == 0)
                    send_height(hhr_pkg::ACT_COLOUR, pick_height(0, base));
            end
        end
        in_ch.valid <= 1'b0;

        // Drain: let the count see the last transfer, wait for every colour
        // result, then let the unit settle.
        @(posedge i_clk);
        wait (open_count == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && open_count == 0) begin
            $display("[height_to_hue_ramp_colour_unit] OK");
        end else begin
            $display("[height_to_hue_ramp_colour_unit] ERROR");
        end
        $finish;
    end

    // Watchdog: the slowest correct run needs a few ms; stop well beyond that.
    initial begin
        #20_000_000;
        $display("[height_to_hue_ramp_colour_unit] ERROR");
        $finish;
    end

endmodule

FILE: height_to_hue_ramp_colour_unit.f
+incdir+hdl
hdl/hhr_pkg.sv
hdl/hhr_chan_if.sv
hdl/hhr_div.sv
hdl/height_to_hue_ramp_colour_unit.sv
verif/height_to_hue_ramp_colour_unit_checker.sv
verif/height_to_hue_ramp_colour_unit_tb.sv
